// ===== sv/b64_pkg.sv =====
// Shared types, character codes and alphabet functions for the Base64 codec.
package b64_pkg;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam int unsigned MAX_RES = 4;

  localparam logic [1:0] POS_0 = 2'd0;
  localparam logic [1:0] POS_1 = 2'd1;
  localparam logic [1:0] POS_2 = 2'd2;
  localparam logic [1:0] POS_3 = 2'd3;

  // Results produced by one accepted word, sent one per cycle by the output buffer while the output is ready.
  typedef struct packed {
    logic [2:0]                cnt;
    logic [MAX_RES-1:0][7:0]   chars;
  } res_t;

  typedef struct packed {
    logic [1:0]  pos;
    logic [23:0] held;
    logic        pad;
  } grp_t;

  function automatic logic [7:0] alpha(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] r;
    w = {2'b00, v};
    if (v < 6'd26) begin
      r = w + 8'd65;
    end else if (v < 6'd52) begin
      r = w + 8'd71;
    end else if (v < 6'd62) begin
      r = w - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

  // Characters outside the alphabet map to zero.
  function automatic logic [5:0] sextet(input logic [7:0] c);
    logic [7:0] d;
    logic [5:0] r;
    d = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
    end else if (c == 8'h2B) begin
      d = 8'd62;
    end else if (c == 8'h2F) begin
      d = 8'd63;
    end
    r = d[5:0];
    return r;
  endfunction

endpackage

// ===== sv/b64_if.sv =====
// Valid/ready stream interfaces for the input and result words of the codec.
interface b64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== sv/base64_codec_stream_unit.sv =====
// Streaming Base64 codec, standard alphabet, direction chosen by a mode register.
// An input word is taken in the cycle its results are computed and lands in a
// result register that sends one word per cycle while the output is ready, so
// the single output port sets the rate. A new input is taken in the same cycle
// the last pending result leaves. Writing the mode register clears the group
// position and must only happen while idle.
module base64_codec_stream_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  b64_in_if.sink      in_ch,
  b64_out_if.source   out_ch
);

  b64_pkg::res_t res;
  logic          free;
  logic          take;

  assign in_ch.ready = free;
  assign take        = in_ch.valid && free;

  b64_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .byte_i      (in_ch.in_byte),
    .last_i      (in_ch.in_last),
    .res_o       (res)
  );

  b64_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take),
    .res_i  (res),
    .free_o (free),
    .out_ch (out_ch)
  );

endmodule

// ===== sv/b64_core.sv =====
// Group state and per-word encode/decode logic of the Base64 codec.
module b64_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             take_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output b64_pkg::res_t    res_o
);

  logic            mode_q;
  b64_pkg::grp_t   grp_q, grp_d;
  b64_pkg::res_t   res;
  logic [5:0]      v;
  logic            is_pad;
  logic [23:0]     held_n;

  assign v      = b64_pkg::sextet(byte_i);
  assign is_pad = (byte_i == b64_pkg::CHAR_PAD);

  always_comb begin
    grp_d     = grp_q;
    res.cnt   = 3'd0;
    res.chars = '0;
    held_n    = grp_q.held;
    if (!mode_q) begin
      unique case (grp_q.pos)
        b64_pkg::POS_1: begin
          res.chars[0] = b64_pkg::alpha({grp_q.held[17:16], byte_i[7:4]});
          if (last_i) begin
            res.chars[1] = b64_pkg::alpha({byte_i[3:0], 2'b00});
            res.chars[2] = b64_pkg::CHAR_PAD;
            res.cnt      = 3'd3;
            grp_d        = '0;
          end else begin
            res.cnt        = 3'd1;
            grp_d.held     = grp_q.held | {8'd0, byte_i, 8'd0};
            grp_d.pos      = b64_pkg::POS_2;
          end
        end
        b64_pkg::POS_2: begin
          res.chars[0] = b64_pkg::alpha({grp_q.held[11:8], byte_i[7:6]});
          res.chars[1] = b64_pkg::alpha(byte_i[5:0]);
          res.cnt      = 3'd2;
          grp_d        = '0;
        end
        default: begin
          // Position three cannot arise while encoding; it acts as position zero.
          res.chars[0] = b64_pkg::alpha(byte_i[7:2]);
          if (last_i) begin
            res.chars[1] = b64_pkg::alpha({byte_i[1:0], 4'b0000});
            res.chars[2] = b64_pkg::CHAR_PAD;
            res.chars[3] = b64_pkg::CHAR_PAD;
            res.cnt      = 3'd4;
            grp_d        = '0;
          end else begin
            res.cnt    = 3'd1;
            grp_d.held = {byte_i, 16'd0};
            grp_d.pos  = b64_pkg::POS_1;
          end
        end
      endcase
    end else begin
      unique case (grp_q.pos)
        b64_pkg::POS_0: begin
          // Line breaks between groups are dropped without touching state.
          if (byte_i != b64_pkg::CHAR_CR && byte_i != b64_pkg::CHAR_LF) begin
            grp_d.held = {v, 18'd0};
            grp_d.pad  = 1'b0;
            grp_d.pos  = b64_pkg::POS_1;
          end
        end
        b64_pkg::POS_1: begin
          held_n       = grp_q.held | {6'd0, v, 12'd0};
          grp_d.held   = held_n;
          res.chars[0] = held_n[23:16];
          res.cnt      = 3'd1;
          grp_d.pos    = b64_pkg::POS_2;
        end
        b64_pkg::POS_2: begin
          if (is_pad) begin
            grp_d.pad = 1'b1;
          end else begin
            held_n       = grp_q.held | {12'd0, v, 6'd0};
            grp_d.held   = held_n;
            res.chars[0] = held_n[15:8];
            res.cnt      = 3'd1;
          end
          grp_d.pos = b64_pkg::POS_3;
        end
        default: begin
          held_n = grp_q.held | {18'd0, v};
          if (!is_pad && !grp_q.pad) begin
            res.chars[0] = held_n[7:0];
            res.cnt      = 3'd1;
          end
          grp_d = '0;
        end
      endcase
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      grp_q  <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
      grp_q  <= '0;
    end else if (take_i) begin
      grp_q <= grp_d;
    end
  end

endmodule

// ===== sv/b64_obuf.sv =====
// Result register: holds the words of one input and sends them one per cycle while the output is ready.
module b64_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  b64_pkg::res_t     res_i,
  output logic              free_o,
  b64_out_if.source         out_ch
);

  logic [2:0]                       cnt_q;
  logic [1:0]                       ptr_q;
  logic [b64_pkg::MAX_RES-1:0][7:0] char_q;
  logic                             pop;

  assign out_ch.valid    = (cnt_q != 3'd0);
  assign out_ch.out_byte = char_q[ptr_q];
  assign out_ch.out_last = (cnt_q == 3'd1);
  assign pop             = out_ch.valid && out_ch.ready;
  // A new input may enter as the last pending word leaves.
  assign free_o          = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ch.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      ptr_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= res_i.cnt;
      ptr_q <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
      ptr_q <= ptr_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      char_q <= res_i.chars;
    end
  end

endmodule

// ===== sv/b64_checker.sv =====
// Port-level checks of the Base64 codec, bound to the top level.
module b64_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result word changed");

  // A new word enters only when the pending results are gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && out_valid |-> out_ready && out_last)
    else $error("input taken over pending results");

  // A result that is not the last of its input is followed by another.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("result sequence cut short");

  // After the last result leaves with no new input, the output goes idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_last && !(in_valid && in_ready) |=> !out_valid)
    else $error("result invented after last");

endmodule

bind base64_codec_stream_unit b64_checker u_b64_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);
